// ----- rtl/tga_rle_pixel_decoder_core_defines.svh -----
// Assertion macros for the RLE Targa pixel decoder.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef TGA_RLE_PIXEL_DECODER_CORE_DEFINES_SVH
`define TGA_RLE_PIXEL_DECODER_CORE_DEFINES_SVH

`ifndef SYNTH
// Implication check, disabled while reset is asserted.
`define TGA_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("tga_rle check failed");
// Condition that must never be seen at a clock edge.
`define TGA_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
    else $error("tga_rle forbidden condition seen");
`else
`define TGA_ASSERT(label, clk, rst_n, prop)
`define TGA_ASSERT_NEVER(label, clk, rst_n, cond)
`endif

`endif

// ----- rtl/tga_rle_pkg.sv -----
// Shared types and constants for the RLE Targa pixel decoder.
// No dependencies; imported by every module of the block.
package tga_rle_pkg;

  // Decoder phase
  typedef enum logic [1:0] {
    PH_SPEC   = 2'd0,
    PH_HEADER = 2'd1,
    PH_PIXEL  = 2'd2,
    PH_IDLE   = 2'd3
  } phase_e;

  // Result kind codes
  typedef enum logic {
    KIND_PIXEL = 1'b0,
    KIND_ERROR = 1'b1
  } kind_e;

  localparam logic [2:0] SPEC_LAST  = 3'd5;  // descriptor byte index
  localparam logic [7:0] DEPTH_24   = 8'd24;
  localparam logic [7:0] DEPTH_32   = 8'd32;
  localparam logic [7:0] RUN_BIAS   = 8'd127;
  localparam logic [1:0] LAST_BYTE3 = 2'd2;  // last color byte index, 24 bpp
  localparam logic [1:0] LAST_BYTE4 = 2'd3;  // last color byte index, 32 bpp

  // One input request
  typedef struct packed {
    logic       restart;
    logic [7:0] data_byte;
  } in_item_t;

  // One result
  typedef struct packed {
    kind_e      kind;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       has_alpha;
    logic [7:0] run_length;
    logic       last_pixel;
  } result_t;

endpackage

// ----- rtl/tga_rle_in_stage.sv -----
// Input register of the RLE Targa decoder: holds one accepted request.
// Depends on tga_rle_pkg.
module tga_rle_in_stage import tga_rle_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_item_t in_item_i,
  input  logic     advance_i,   // downstream takes the held request this cycle
  output logic     held_valid_o,
  output in_item_t held_item_o
);

  logic     valid_q, valid_d;
  in_item_t item_q;
  logic     load;

  assign in_ready_o = !valid_q || advance_i;
  assign load       = in_valid_i && in_ready_o;

  // Occupancy
  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= in_item_i;
    end
  end

  assign held_valid_o = valid_q;
  assign held_item_o  = item_q;

endmodule

// ----- rtl/tga_rle_decode.sv -----
// Stream decoder of the RLE Targa block: image spec, packet headers, pixels.
// Depends on tga_rle_pkg and tga_rle_pixel_decoder_core_defines.svh.
`include "tga_rle_pixel_decoder_core_defines.svh"
module tga_rle_decode import tga_rle_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     step_i,      // one request is consumed this cycle
  input  in_item_t item_i,
  output logic     res_valid_o,
  output result_t  res_o
);

  phase_e      phase_q, phase_d;
  logic [2:0]  spec_idx_q, spec_idx_d;
  logic [15:0] width_q, width_d;
  logic [15:0] height_q, height_d;
  logic [7:0]  depth_q, depth_d;
  logic        four_q, four_d;
  logic        raw_q, raw_d;
  logic [7:0]  pkt_left_q, pkt_left_d;
  logic [1:0]  bip_q, bip_d;
  logic [23:0] hold_q, hold_d;
  logic [31:0] pix_left_q, pix_left_d;

  phase_e      cur_phase;
  logic [2:0]  cur_idx;
  logic [7:0]  b;
  logic [31:0] area;
  logic [7:0]  count;
  logic        bad_spec;

  assign b        = item_i.data_byte;
  assign area     = {16'd0, width_q} * {16'd0, height_q};
  assign bad_spec = ((depth_q != DEPTH_24) && (depth_q != DEPTH_32))
                    || (width_q == 16'd0) || (height_q == 16'd0);

  // Next state and result
  always_comb begin
    phase_d     = phase_q;
    spec_idx_d  = spec_idx_q;
    width_d     = width_q;
    height_d    = height_q;
    depth_d     = depth_q;
    four_d      = four_q;
    raw_d       = raw_q;
    pkt_left_d  = pkt_left_q;
    bip_d       = bip_q;
    hold_d      = hold_q;
    pix_left_d  = pix_left_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    count       = 8'd0;
    // restart forces the byte into the first spec slot
    cur_phase   = item_i.restart ? PH_SPEC : phase_q;
    cur_idx     = item_i.restart ? 3'd0 : spec_idx_q;

    if (step_i) begin
      case (cur_phase)
        PH_SPEC: begin
          case (cur_idx)
            3'd0: width_d  = {8'd0, b};
            3'd1: width_d  = {b, width_q[7:0]};
            3'd2: height_d = {8'd0, b};
            3'd3: height_d = {b, height_q[7:0]};
            3'd4: depth_d  = b;
            default: ;
          endcase
          phase_d = PH_SPEC;
          if (cur_idx < SPEC_LAST) begin
            spec_idx_d = cur_idx + 3'd1;
          end else begin
            // descriptor byte: spec complete
            spec_idx_d = 3'd0;
            bip_d      = 2'd0;
            pkt_left_d = 8'd0;
            raw_d      = 1'b0;
            hold_d     = 24'd0;
            four_d     = (depth_q == DEPTH_32);
            if (bad_spec) begin
              pix_left_d  = 32'd0;
              phase_d     = PH_IDLE;
              res_valid_o = 1'b1;
              res_o.kind  = KIND_ERROR;
            end else begin
              pix_left_d = area;
              phase_d    = PH_HEADER;
            end
          end
        end

        PH_HEADER: begin
          if (!b[7]) begin
            raw_d      = 1'b1;
            pkt_left_d = b + 8'd1;
          end else begin
            raw_d      = 1'b0;
            pkt_left_d = b - RUN_BIAS;
          end
          bip_d   = 2'd0;
          hold_d  = 24'd0;
          phase_d = PH_PIXEL;
        end

        PH_PIXEL: begin
          if (bip_q < (four_q ? LAST_BYTE4 : LAST_BYTE3)) begin
            case (bip_q)
              2'd0:    hold_d[7:0]   = b;
              2'd1:    hold_d[15:8]  = b;
              default: hold_d[23:16] = b;
            endcase
            bip_d = bip_q + 2'd1;
          end else begin
            // last byte of the pixel: emit
            if (raw_q) begin
              count = 8'd1;
            end else if (pix_left_q < {24'd0, pkt_left_q}) begin
              count = pix_left_q[7:0];
            end else begin
              count = pkt_left_q;
            end
            pix_left_d         = pix_left_q - {24'd0, count};
            pkt_left_d         = raw_q ? (pkt_left_q - 8'd1) : 8'd0;
            res_valid_o        = 1'b1;
            res_o.kind         = KIND_PIXEL;
            res_o.red          = four_q ? hold_q[23:16] : b;
            res_o.green        = hold_q[15:8];
            res_o.blue         = hold_q[7:0];
            res_o.alpha        = four_q ? b : 8'd0;
            res_o.has_alpha    = four_q;
            res_o.run_length   = count;
            res_o.last_pixel   = (pix_left_d == 32'd0);
            bip_d              = 2'd0;
            hold_d             = 24'd0;
            if (pix_left_d == 32'd0) begin
              phase_d = PH_IDLE;
            end else if (pkt_left_d == 8'd0) begin
              phase_d = PH_HEADER;
            end
          end
        end

        default: ;  // idle: byte dropped
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_SPEC;
      spec_idx_q <= 3'd0;
      width_q    <= 16'd0;
      height_q   <= 16'd0;
      depth_q    <= 8'd0;
      four_q     <= 1'b0;
      raw_q      <= 1'b0;
      pkt_left_q <= 8'd0;
      bip_q      <= 2'd0;
      hold_q     <= 24'd0;
      pix_left_q <= 32'd0;
    end else begin
      phase_q    <= phase_d;
      spec_idx_q <= spec_idx_d;
      width_q    <= width_d;
      height_q   <= height_d;
      depth_q    <= depth_d;
      four_q     <= four_d;
      raw_q      <= raw_d;
      pkt_left_q <= pkt_left_d;
      bip_q      <= bip_d;
      hold_q     <= hold_d;
      pix_left_q <= pix_left_d;
    end
  end

  // Checks
  `TGA_ASSERT(a_last_goes_idle, clk_i, rst_ni,
              (res_valid_o && res_o.last_pixel) |=> (phase_q == PH_IDLE))
  `TGA_ASSERT(a_error_no_count, clk_i, rst_ni,
              (res_valid_o && (res_o.kind == KIND_ERROR)) |->
              ((res_o.run_length == 8'd0) && (phase_d == PH_IDLE)))
  `TGA_ASSERT_NEVER(a_pixel_with_none_due, clk_i, rst_ni,
                    (phase_q == PH_PIXEL) && (pix_left_q == 32'd0))
  `TGA_ASSERT(a_run_in_range, clk_i, rst_ni,
              (res_valid_o && (res_o.kind == KIND_PIXEL)) |->
              ((res_o.run_length != 8'd0) && (res_o.run_length <= 8'd128)))

endmodule

// ----- rtl/tga_rle_out_reg.sv -----
// Result register of the RLE Targa decoder, drives the master stream side.
// Depends on tga_rle_pkg.
module tga_rle_out_reg import tga_rle_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    advance_i,   // register may take a new value this cycle
  input  logic    res_valid_i,
  input  result_t res_i,
  output logic    out_valid_o,
  output result_t out_o
);

  logic    valid_q, valid_d;
  result_t res_q;

  assign valid_d = advance_i ? res_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    if (advance_i && res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_o       = res_q;

endmodule

// ----- rtl/tga_rle_pixel_decoder_core.sv -----
// RLE Targa pixel decoder: one byte per cycle in, one result per pixel, run or bad spec out.
// Path: an accepted byte waits in the input register, is decoded, and its result is registered.
// Throughput: one byte per cycle; set by the single decode step between input and result regs.
// Stalls on the master side hold the result register and backpressure the slave side.
// Reset (rst_ni low, asynchronous) empties both registers and waits for image-spec bytes.
module tga_rle_pixel_decoder_core import tga_rle_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] restart
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha, [39:32] run_length
  output logic [39:0] m_axis_tdata,
  output logic [1:0]  m_axis_tuser,   // [0] kind, [1] has_alpha
  output logic        m_axis_tlast    // last_pixel
);

  in_item_t in_item, held_item;
  logic     held_valid;
  logic     advance;
  logic     res_valid;
  result_t  res, out_res;

  assign in_item.data_byte = s_axis_tdata;
  assign in_item.restart   = s_axis_tuser;

  // Pipeline moves whenever the result register is free or being drained
  assign advance = !m_axis_tvalid || m_axis_tready;

  tga_rle_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_item_i    (in_item),
    .advance_i    (advance),
    .held_valid_o (held_valid),
    .held_item_o  (held_item)
  );

  tga_rle_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (held_valid && advance),
    .item_i      (held_item),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  tga_rle_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (advance),
    .res_valid_i (res_valid),
    .res_i       (res),
    .out_valid_o (m_axis_tvalid),
    .out_o       (out_res)
  );

  assign m_axis_tdata = {out_res.run_length, out_res.alpha, out_res.blue,
                         out_res.green, out_res.red};
  assign m_axis_tuser = {out_res.has_alpha, out_res.kind};
  assign m_axis_tlast = out_res.last_pixel;

endmodule

// ----- dv/tga_rle_pixel_decoder_core_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for tga_rle_pixel_decoder_core: directed byte table, then random images.
// Depends on tga_rle_pkg and the core RTL; results are checked against an in-bench pixel decoder.
module tga_rle_pixel_decoder_core_tb import tga_rle_pkg::*; ();

  localparam int unsigned STALL_LIMIT = 2000;  // cycles without any request or result
  localparam int unsigned RAND_REQS   = 950;
  localparam int unsigned CALM_AFTER  = 800;   // no idling past this many random requests
  localparam int unsigned HOLD_CYCLES = 64;
  localparam result_t     NO_RESULT   = '0;

  typedef struct {
    logic [7:0] data_byte;
    logic       restart;
    bit         typed;
    result_t    want;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] data_byte
  logic        s_axis_tuser;   // [0] restart
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha, [39:32] run_length
  logic [39:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;   // [0] kind, [1] has_alpha
  logic        m_axis_tlast;   // last_pixel

  // Decoder state mirrored by the bench
  phase_e      dec_phase  = PH_SPEC;
  logic [2:0]  spec_idx   = '0;
  logic [15:0] img_w      = '0;
  logic [15:0] img_h      = '0;
  logic [7:0]  depth_code = '0;
  logic        four_bpp   = 1'b0;
  logic        raw_pkt    = 1'b0;
  logic [7:0]  pkt_left   = '0;
  logic [1:0]  byte_idx   = '0;
  logic [23:0] colour     = '0;  // B 7:0, G 15:8, R 23:16
  logic [31:0] px_left    = '0;

  result_t     pending_px[$];
  stim_row_t   dir_rows[$];
  result_t     got_px;
  int unsigned mismatches   = 0;
  int unsigned reqs_sent    = 0;
  int unsigned quiet_cycles = 0;
  bit          idle_on      = 1'b1;
  bit          hold_rx      = 1'b0;

  tga_rle_pixel_decoder_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Pixel decoder: one stream byte in, at most one result out
  function automatic bit decode_byte(input logic [7:0] b, input logic rs, output result_t r);
    logic [1:0]  last_idx;
    logic [31:0] cnt;
    logic [7:0]  alpha_b;
    r = NO_RESULT;
    decode_byte = 1'b0;
    if (rs) begin
      dec_phase = PH_SPEC;
      spec_idx  = '0;
    end
    case (dec_phase)
      PH_SPEC: begin
        case (spec_idx)
          3'd0: img_w = {8'h00, b};
          3'd1: img_w[15:8] = b;
          3'd2: img_h = {8'h00, b};
          3'd3: img_h[15:8] = b;
          3'd4: depth_code = b;
          default: ;  // descriptor byte is dropped
        endcase
        if (spec_idx < SPEC_LAST) begin
          spec_idx = spec_idx + 3'd1;
        end else begin
          spec_idx = '0;
          byte_idx = '0;
          pkt_left = '0;
          raw_pkt  = 1'b0;
          colour   = '0;
          four_bpp = (depth_code == DEPTH_32);
          if ((depth_code != DEPTH_24 && depth_code != DEPTH_32) || img_w == 0 || img_h == 0) begin
            px_left     = '0;
            dec_phase   = PH_IDLE;
            r.kind      = KIND_ERROR;
            decode_byte = 1'b1;
          end else begin
            px_left   = {16'h0000, img_w} * {16'h0000, img_h};
            dec_phase = PH_HEADER;
          end
        end
      end
      PH_HEADER: begin
        if (b < 8'd128) begin
          raw_pkt  = 1'b1;
          pkt_left = b + 8'd1;
        end else begin
          raw_pkt  = 1'b0;
          pkt_left = b - RUN_BIAS;
        end
        byte_idx  = '0;
        colour    = '0;
        dec_phase = PH_PIXEL;
      end
      PH_PIXEL: begin
        last_idx = four_bpp ? LAST_BYTE4 : LAST_BYTE3;
        if (byte_idx < last_idx) begin
          colour[8*byte_idx +: 8] = b;
          byte_idx = byte_idx + 2'd1;
        end else begin
          if (four_bpp) begin
            alpha_b = b;
          end else begin
            colour[23:16] = b;
            alpha_b = 8'h00;
          end
          byte_idx = '0;
          // runs are clipped to the pixels still due
          if (raw_pkt) cnt = 32'd1;
          else cnt = ({24'h0, pkt_left} < px_left) ? {24'h0, pkt_left} : px_left;
          px_left  = px_left - cnt;
          pkt_left = raw_pkt ? pkt_left - 8'd1 : 8'd0;
          r.kind       = KIND_PIXEL;
          r.red        = colour[23:16];
          r.green      = colour[15:8];
          r.blue       = colour[7:0];
          r.alpha      = alpha_b;
          r.has_alpha  = four_bpp;
          r.run_length = cnt[7:0];
          r.last_pixel = (px_left == 0);
          decode_byte  = 1'b1;
          colour = '0;
          if (px_left == 0) dec_phase = PH_IDLE;
          else if (pkt_left == 0) dec_phase = PH_HEADER;
        end
      end
      default: ;  // idle: wait for restart
    endcase
  endfunction

  task automatic log_mismatch(input string what, input logic [7:0] got, input logic [7:0] want);
    mismatches++;
    if (mismatches <= 40)
      $display("mismatch on %s: got %0h, want %0h at %0t", what, got, want, $realtime);
  endtask

  task automatic check_result(input result_t got, input result_t want);
    if (got.kind != want.kind) log_mismatch("kind", 8'(got.kind), 8'(want.kind));
    if (got.red != want.red) log_mismatch("red", got.red, want.red);
    if (got.green != want.green) log_mismatch("green", got.green, want.green);
    if (got.blue != want.blue) log_mismatch("blue", got.blue, want.blue);
    if (got.alpha != want.alpha) log_mismatch("alpha", got.alpha, want.alpha);
    if (got.has_alpha != want.has_alpha)
      log_mismatch("has_alpha", 8'(got.has_alpha), 8'(want.has_alpha));
    if (got.run_length != want.run_length)
      log_mismatch("run_length", got.run_length, want.run_length);
    if (got.last_pixel != want.last_pixel)
      log_mismatch("last_pixel", 8'(got.last_pixel), 8'(want.last_pixel));
  endtask

  function automatic void add_row(input logic [7:0] b, input logic rs, input bit typed,
                                  input result_t want);
    stim_row_t row;
    row.data_byte = b;
    row.restart   = rs;
    row.typed     = typed;
    row.want      = want;
    dir_rows.push_back(row);
  endfunction

  // Offer one request, wait for it to be taken, then log what it should produce
  task automatic send_req(input logic [7:0] b, input logic rs, input bit typed,
                          input result_t want);
    result_t r;
    bit      made;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= rs;
    do @(posedge clk_i); while (!s_axis_tready);
    if (rs || dec_phase != PH_IDLE) reqs_sent++;
    made = decode_byte(b, rs, r);
    if (typed) pending_px.push_back(want);
    else if (made) pending_px.push_back(r);
    // sender gap with tvalid low, about one request in eight, while idling is on and no hold runs
    if (idle_on && !hold_rx && $urandom_range(0, 7) == 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(0, 15)) @(negedge clk_i);
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic rs);
    send_req(b, rs, 1'b0, NO_RESULT);
  endtask

  // One random image: mostly small and well formed, some bad specs, cut-offs and huge sizes
  task automatic send_rand_image();
    int unsigned sel, w, h, rem, npx, hdr, run_n, nbytes, cut_at, px_bytes;
    logic [7:0]  depth_b;
    sel     = $urandom_range(0, 99);
    w       = $urandom_range(1, 4);
    h       = $urandom_range(1, 4);
    depth_b = $urandom_range(0, 1) ? DEPTH_32 : DEPTH_24;
    cut_at  = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 24) : 0;
    if (sel < 4) begin
      depth_b = 8'($urandom_range(0, 255));
    end else if (sel < 8) begin
      if ($urandom_range(0, 1)) w = 0;
      else h = 0;
    end else if (sel < 12) begin
      w = $urandom_range(0, 65535);
      h = $urandom_range(1, 65535);
      cut_at = $urandom_range(8, 40);
    end
    send_byte(w[7:0], 1'b1);
    send_byte(w[15:8], 1'b0);
    send_byte(h[7:0], 1'b0);
    send_byte(h[15:8], 1'b0);
    send_byte(depth_b, 1'b0);
    send_byte(8'($urandom_range(0, 255)), 1'b0);
    px_bytes = (depth_b == DEPTH_32) ? 4 : 3;
    rem = ((depth_b == DEPTH_24 || depth_b == DEPTH_32) && w != 0 && h != 0) ? w * h : 0;
    nbytes = 0;
    while (rem > 0) begin
      if ($urandom_range(0, 1)) begin
        hdr = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 3);
        npx = (hdr + 1 < rem) ? hdr + 1 : rem;
        rem = rem - npx;
      end else begin
        hdr   = ($urandom_range(0, 7) == 0) ? $urandom_range(128, 255) : $urandom_range(128, 131);
        run_n = hdr - 127;
        npx   = 1;
        rem   = rem - ((run_n < rem) ? run_n : rem);
      end
      send_byte(hdr[7:0], 1'b0);
      nbytes++;
      if (cut_at != 0 && nbytes >= cut_at) return;
      repeat (npx * px_bytes) begin
        send_byte(8'($urandom_range(0, 255)), 1'b0);
        nbytes++;
        if (cut_at != 0 && nbytes >= cut_at) return;
      end
    end
    // trailing bytes after a finished image or an error are dropped by the block
    if ($urandom_range(0, 4) == 0)
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)), 1'b0);
  endtask

  // Stimulus and final verdict
  initial begin
    result_t err_res, last_res;
    bit      did_hold, did_drain;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    did_hold      = 1'b0;
    did_drain     = 1'b0;

    err_res      = NO_RESULT;
    err_res.kind = KIND_ERROR;
    last_res            = NO_RESULT;
    last_res.kind       = KIND_PIXEL;
    last_res.red        = 8'hFF;
    last_res.green      = 8'h80;
    last_res.blue       = 8'h00;
    last_res.alpha      = 8'h7F;
    last_res.has_alpha  = 1'b1;
    last_res.run_length = 8'd2;
    last_res.last_pixel = 1'b1;

    // zero width with extreme height: error result on the descriptor byte
    add_row(8'h00, 1'b1, 1'b0, NO_RESULT);
    add_row(8'h00, 1'b0, 1'b0, NO_RESULT);
    add_row(8'hFF, 1'b0, 1'b0, NO_RESULT);
    add_row(8'hFF, 1'b0, 1'b0, NO_RESULT);
    add_row(DEPTH_24, 1'b0, 1'b0, NO_RESULT);
    add_row(8'hFF, 1'b0, 1'b1, err_res);
    // dropped while idle
    add_row(8'h55, 1'b0, 1'b0, NO_RESULT);
    // restart in the middle of the spec bytes
    add_row(8'h05, 1'b1, 1'b0, NO_RESULT);
    add_row(8'h00, 1'b0, 1'b0, NO_RESULT);
    // 3x1 image, 32 bpp
    add_row(8'h03, 1'b1, 1'b0, NO_RESULT);
    add_row(8'h00, 1'b0, 1'b0, NO_RESULT);
    add_row(8'h01, 1'b0, 1'b0, NO_RESULT);
    add_row(8'h00, 1'b0, 1'b0, NO_RESULT);
    add_row(DEPTH_32, 1'b0, 1'b0, NO_RESULT);
    add_row(8'h00, 1'b0, 1'b0, NO_RESULT);
    // raw packet of one pixel
    add_row(8'h00, 1'b0, 1'b0, NO_RESULT);
    add_row(8'h11, 1'b0, 1'b0, NO_RESULT);
    add_row(8'h22, 1'b0, 1'b0, NO_RESULT);
    add_row(8'h33, 1'b0, 1'b0, NO_RESULT);
    add_row(8'h44, 1'b0, 1'b0, NO_RESULT);
    // longest run, clipped to the two pixels left
    add_row(8'hFF, 1'b0, 1'b0, NO_RESULT);
    add_row(8'h00, 1'b0, 1'b0, NO_RESULT);
    add_row(8'h80, 1'b0, 1'b0, NO_RESULT);
    add_row(8'hFF, 1'b0, 1'b0, NO_RESULT);
    add_row(8'h7F, 1'b0, 1'b1, last_res);

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_rows[i])
      send_req(dir_rows[i].data_byte, dir_rows[i].restart, dir_rows[i].typed, dir_rows[i].want);

    reqs_sent = 0;
    while (reqs_sent < RAND_REQS) begin
      if (!did_hold && reqs_sent >= 300) begin
        did_hold = 1'b1;
        hold_rx  = 1'b1;
      end
      if (!did_drain && reqs_sent >= 600) begin
        did_drain = 1'b1;
        // stop offering while everything in flight drains
        @(negedge clk_i);
        s_axis_tvalid <= 1'b0;
        while (pending_px.size() != 0) @(posedge clk_i);
      end
      idle_on = (reqs_sent < CALM_AFTER);
      send_rand_image();
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;

    while (pending_px.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && pending_px.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Result side ready: random bursts, plus one long hold to back up the input
  initial begin : rx_ready
    int unsigned n;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_rx) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
        hold_rx = 1'b0;
      end else begin
        n = $urandom_range(1, 16);
        m_axis_tready <= !(idle_on && $urandom_range(0, 2) == 0);
        repeat (n - 1) @(negedge clk_i);
      end
    end
  end

  // Compare each result with the oldest one due
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_px.kind       = kind_e'(m_axis_tuser[0]);
      got_px.red        = m_axis_tdata[7:0];
      got_px.green      = m_axis_tdata[15:8];
      got_px.blue       = m_axis_tdata[23:16];
      got_px.alpha      = m_axis_tdata[31:24];
      got_px.has_alpha  = m_axis_tuser[1];
      got_px.run_length = m_axis_tdata[39:32];
      got_px.last_pixel = m_axis_tlast;
      if (pending_px.size() == 0) log_mismatch("result with none due", 8'h00, 8'h00);
      else check_result(got_px, pending_px.pop_front());
    end
  end

  // Watchdog on cycles with no request and no result moving
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

endmodule
